>>> hw/rtl/met_pkg.sv
// Shared types and constants of the Mandelbrot escape-time core.
// Holds the item structs, the register index codes and the multiplier sizes.
// No dependencies.
package met_pkg;

  // Item fields
  localparam int unsigned INDEX_BITS   = 10;
  localparam int unsigned COUNT_BITS   = 12;
  localparam int unsigned COLOR_BITS   = 8;
  localparam int unsigned MOD_CNT_BITS = $clog2(COUNT_BITS);

  // Configuration port
  localparam int unsigned CFG_DATA_BITS  = 64;
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned STEP_BITS      = 63;

  // Shared multiplier: 32x32 partial products of 64-bit operands
  localparam int unsigned MUL_BITS  = 32;
  localparam int unsigned OP_BITS   = 2 * MUL_BITS;
  localparam int unsigned PROD_BITS = 2 * OP_BITS;

  // Number format defaults
  localparam int unsigned WORD_BITS_DEF     = 64;
  localparam int unsigned FRACTION_BITS_DEF = 56;

  // Algorithm constants
  localparam int unsigned ESCAPE_RADIUS_SQ = 4;
  localparam int unsigned NEAR_BAND        = 9;
  localparam int unsigned LIMIT_RESET      = 100;
  localparam int unsigned MAX_COLOR_RESET  = 15;

  // Register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Y  = 3'd1,
    CFG_STEP      = 3'd2,
    CFG_LIMIT     = 3'd3,
    CFG_MAX_COLOR = 3'd4
  } cfg_index_e;

  typedef struct packed {
    logic [INDEX_BITS-1:0] column;
    logic [INDEX_BITS-1:0] row;
  } met_in_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] column_out;
    logic [INDEX_BITS-1:0] row_out;
    logic [COUNT_BITS-1:0] iterations;
    logic                  escaped;
    logic [COLOR_BITS-1:0] color;
  } met_out_t;

endpackage

>>> hw/rtl/met_mul.sv
// Sequential 64x64 unsigned multiplier built on one 32x32 multiplier.
// Issues four partial products, adds each once registered; done_o rises with the last add.
// Depends on met_pkg.
module met_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [met_pkg::OP_BITS-1:0]   a_i,
  input  logic [met_pkg::OP_BITS-1:0]   b_i,
  output logic                          done_o,
  output logic [met_pkg::PROD_BITS-1:0] prod_o
);
  import met_pkg::*;

  logic [OP_BITS-1:0]   a_q, b_q;
  logic                 busy_q;
  logic [1:0]           sel_q;
  logic                 pp_vld_q;
  logic [1:0]           pp_sel_q;
  logic                 done_q;
  logic [OP_BITS-1:0]   pp_q;
  logic [PROD_BITS-1:0] acc_q;
  logic [MUL_BITS-1:0]  a_chunk, b_chunk;
  logic [PROD_BITS-1:0] pp_shifted;

  // Pick the operand halves for the current partial product
  assign a_chunk = sel_q[1] ? a_q[OP_BITS-1:MUL_BITS] : a_q[MUL_BITS-1:0];
  assign b_chunk = sel_q[0] ? b_q[OP_BITS-1:MUL_BITS] : b_q[MUL_BITS-1:0];

  // Align the registered partial product to its weight
  always_comb begin
    case (pp_sel_q)
      2'b00:   pp_shifted = PROD_BITS'(pp_q);
      2'b01,
      2'b10:   pp_shifted = PROD_BITS'(pp_q) << MUL_BITS;
      2'b11:   pp_shifted = PROD_BITS'(pp_q) << (2 * MUL_BITS);
      default: pp_shifted = '0;
    endcase
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      sel_q    <= '0;
      pp_vld_q <= 1'b0;
      pp_sel_q <= '0;
      done_q   <= 1'b0;
    end else begin
      pp_vld_q <= busy_q;
      pp_sel_q <= sel_q;
      done_q   <= pp_vld_q && (pp_sel_q == 2'b11);
      if (start_i) begin
        busy_q <= 1'b1;
        sel_q  <= '0;
      end else if (busy_q) begin
        sel_q <= sel_q + 2'd1;
        if (sel_q == 2'b11) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Operands, partial product and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (busy_q) begin
      pp_q <= a_chunk * b_chunk;
    end
    if (start_i) begin
      acc_q <= '0;
    end else if (pp_vld_q) begin
      acc_q <= acc_q + pp_shifted;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

>>> hw/rtl/mandelbrot_escape_time_core.sv
// Mandelbrot escape-time core: one pixel in, iteration count and color out.
// Uses the sequential multiplier met_mul for every product.
// Depends on met_pkg and met_mul.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o) takes a pixel column and row. The
//   core stalls its input while it works on a pixel, so one pixel is in flight.
// - Output channel (out_valid_o / out_stall_i) presents count, escaped flag and
//   color from an output register; the next pixel is taken while a result waits.
// - Configuration writes (cfg_valid_i / cfg_ready_o) set origin, step, limit
//   and max color; they are always taken and must happen while the core is idle.
// - The shared 32x32 multiplier sets the time to a valid result for a pixel:
//   the coordinates take two products, each iteration three products plus
//   S_T, S_T2, S_ZI and S_ESC to add and test, then S_MOD walks the count
//   bits for the remainder and S_DONE loads the result.
// - A new pixel is taken only once the last has been loaded and the core is idle.
// - Reset clears the sequencer and the output valid and loads the register
//   defaults (limit 100, max color 15, origin and step zero).
// - A stalled result holds in the output register; a finished pixel waits in
//   its last step until the register is free.
module mandelbrot_escape_time_core #(
  parameter int unsigned WORD_BITS     = met_pkg::WORD_BITS_DEF,
  parameter int unsigned FRACTION_BITS = met_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  met_pkg::met_in_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output met_pkg::met_out_t                  out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [met_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [met_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);
  import met_pkg::*;

  localparam logic [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS-1:0] FOUR  =
    WORD_BITS'(ESCAPE_RADIUS_SQ) << FRACTION_BITS;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_CX   = 12'b0000_0000_0010,
    S_CY   = 12'b0000_0000_0100,
    S_T    = 12'b0000_0000_1000,
    S_T2   = 12'b0000_0001_0000,
    S_XY   = 12'b0000_0010_0000,
    S_ZI   = 12'b0000_0100_0000,
    S_RR   = 12'b0000_1000_0000,
    S_II   = 12'b0001_0000_0000,
    S_ESC  = 12'b0010_0000_0000,
    S_MOD  = 12'b0100_0000_0000,
    S_DONE = 12'b1000_0000_0000
  } state_e;

  // Saturating add on two's complement words
  function automatic logic [WORD_BITS-1:0] sat_add(input logic [WORD_BITS-1:0] a,
                                                   input logic [WORD_BITS-1:0] b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      sat_add = s[WORD_BITS] ? W_MIN : W_MAX;
    end else begin
      sat_add = s[WORD_BITS-1:0];
    end
  endfunction

  // Saturating subtract on two's complement words
  function automatic logic [WORD_BITS-1:0] sat_sub(input logic [WORD_BITS-1:0] a,
                                                   input logic [WORD_BITS-1:0] b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      sat_sub = s[WORD_BITS] ? W_MIN : W_MAX;
    end else begin
      sat_sub = s[WORD_BITS-1:0];
    end
  endfunction

  // Magnitude; the most negative word maps to 2^(WORD_BITS-1)
  function automatic logic [WORD_BITS-1:0] mag(input logic [WORD_BITS-1:0] v);
    mag = v[WORD_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  // Scale an unsigned product back to the word format, truncate, saturate
  function automatic logic [WORD_BITS-1:0] fx_result(input logic [PROD_BITS-1:0] p,
                                                     input logic neg);
    logic [PROD_BITS-1:0] q;
    logic [WORD_BITS-1:0] m;
    q = p >> FRACTION_BITS;
    m = q[WORD_BITS-1:0];
    if (|(q >> (WORD_BITS - 1))) begin
      fx_result = neg ? W_MIN : W_MAX;
    end else begin
      fx_result = neg ? (~m + 1'b1) : m;
    end
  endfunction

  // Pixel coordinate from origin and index*step
  function automatic logic [WORD_BITS-1:0] coord(input logic [WORD_BITS-1:0] origin,
                                                 input logic [PROD_BITS-1:0] p);
    if (|(p >> (WORD_BITS - 1))) begin
      coord = W_MAX;
    end else begin
      coord = sat_add(origin, p[WORD_BITS-1:0]);
    end
  endfunction

  // Clamp a written origin to the word range
  function automatic logic [WORD_BITS-1:0] clamp_word(
      input logic [CFG_DATA_BITS-1:0] v);
    logic [CFG_DATA_BITS-WORD_BITS:0] hi;
    hi = v[CFG_DATA_BITS-1:WORD_BITS-1];
    if ((&hi) || !(|hi)) begin
      clamp_word = v[WORD_BITS-1:0];
    end else begin
      clamp_word = v[CFG_DATA_BITS-1] ? W_MIN : W_MAX;
    end
  endfunction

  state_e state_q, state_d;

  // Registers
  logic [WORD_BITS-1:0]  origin_x_q, origin_y_q;
  logic [STEP_BITS-1:0]  step_q;
  logic [COUNT_BITS-1:0] limit_q;
  logic [COLOR_BITS-1:0] max_color_q;

  // Pixel working state
  met_in_t               pix_q;
  logic [WORD_BITS-1:0]  cr_q, ci_q, zr_q, zi_q, zr2_q, zi2_q, t_q;
  logic                  fx_neg_q;
  logic                  esc_q, near_q;
  logic [COUNT_BITS-1:0] iter_q;
  logic [MOD_CNT_BITS-1:0] mod_cnt_q;
  logic [COLOR_BITS-1:0] rem_q;
  logic                  out_valid_q;
  met_out_t              out_q;

  // Multiplier connection
  logic                  mul_start;
  logic [OP_BITS-1:0]    mul_a, mul_b;
  logic                  mul_done;
  logic [PROD_BITS-1:0]  mul_prod;

  logic                  in_acc;
  logic                  out_load;
  logic [WORD_BITS-1:0]  fx_val, coord_val, zsum;
  logic [COUNT_BITS-1:0] lim;
  logic                  escape, stop, near;
  logic [COLOR_BITS:0]   divisor, rem_shift, rem_next;

  met_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Product and coordinate as they leave the multiplier
  assign fx_val    = fx_result(mul_prod, fx_neg_q);
  assign coord_val = coord((state_q == S_CX) ? origin_x_q : origin_y_q, mul_prod);

  // Escape test, stop test and color band
  assign lim     = (limit_q == '0) ? COUNT_BITS'(1) : limit_q;
  assign zsum    = sat_add(zr2_q, zi2_q);
  assign escape  = $signed(zsum) >= $signed(FOUR);
  assign stop    = escape || (iter_q == lim);
  assign near    = ({1'b0, iter_q} + (COUNT_BITS+1)'(NEAR_BAND)) >= {1'b0, lim};

  // One restoring step of count mod (max_color + 1)
  assign divisor   = {1'b0, max_color_q} + 1'b1;
  assign rem_shift = {rem_q, iter_q[mod_cnt_q]};
  assign rem_next  = (rem_shift >= divisor) ? (rem_shift - divisor) : rem_shift;

  // Sequencer and multiplier operand selection
  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          mul_start = 1'b1;
          mul_a     = OP_BITS'(in_data_i.column);
          mul_b     = OP_BITS'(step_q);
          state_d   = S_CX;
        end
      end
      S_CX: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = OP_BITS'(pix_q.row);
          mul_b     = OP_BITS'(step_q);
          state_d   = S_CY;
        end
      end
      S_CY: begin
        if (mul_done) begin
          state_d = S_T;
        end
      end
      S_T: begin
        mul_start = 1'b1;
        mul_a     = OP_BITS'(mag(zr_q));
        mul_b     = OP_BITS'(mag(zi_q));
        state_d   = S_T2;
      end
      S_T2: begin
        state_d = S_XY;
      end
      S_XY: begin
        if (mul_done) begin
          state_d = S_ZI;
        end
      end
      S_ZI: begin
        mul_start = 1'b1;
        mul_a     = OP_BITS'(mag(zr_q));
        mul_b     = OP_BITS'(mag(zr_q));
        state_d   = S_RR;
      end
      S_RR: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = OP_BITS'(mag(zi_q));
          mul_b     = OP_BITS'(mag(zi_q));
          state_d   = S_II;
        end
      end
      S_II: begin
        if (mul_done) begin
          state_d = S_ESC;
        end
      end
      S_ESC: begin
        state_d = stop ? S_MOD : S_T;
      end
      S_MOD: begin
        if (mod_cnt_q == '0) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state, counters and registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iter_q      <= '0;
      mod_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      step_q      <= '0;
      limit_q     <= COUNT_BITS'(LIMIT_RESET);
      max_color_q <= COLOR_BITS'(MAX_COLOR_RESET);
    end else begin
      state_q <= state_d;
      // Count iterations
      if ((state_q == S_CY) && mul_done) begin
        iter_q <= '0;
      end else if ((state_q == S_XY) && mul_done) begin
        iter_q <= iter_q + 1'b1;
      end
      // Walk the count bits for the remainder
      if (state_q == S_ESC) begin
        mod_cnt_q <= MOD_CNT_BITS'(COUNT_BITS - 1);
      end else if (state_q == S_MOD) begin
        mod_cnt_q <= mod_cnt_q - 1'b1;
      end
      // Hold the result until taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // Register writes
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ORIGIN_X:  origin_x_q  <= clamp_word(cfg_data_i);
          CFG_ORIGIN_Y:  origin_y_q  <= clamp_word(cfg_data_i);
          CFG_STEP:      step_q      <= cfg_data_i[STEP_BITS-1:0];
          CFG_LIMIT:     limit_q     <= cfg_data_i[COUNT_BITS-1:0];
          CFG_MAX_COLOR: max_color_q <= cfg_data_i[COLOR_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // Pixel datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          pix_q <= in_data_i;
        end
      end
      S_CX: begin
        if (mul_done) begin
          cr_q <= coord_val;
        end
      end
      S_CY: begin
        if (mul_done) begin
          ci_q  <= coord_val;
          zr_q  <= '0;
          zi_q  <= '0;
          zr2_q <= '0;
          zi2_q <= '0;
        end
      end
      S_T: begin
        t_q      <= sat_sub(zr2_q, zi2_q);
        fx_neg_q <= zr_q[WORD_BITS-1] ^ zi_q[WORD_BITS-1];
      end
      S_T2: begin
        t_q <= sat_add(t_q, cr_q);
      end
      S_XY: begin
        if (mul_done) begin
          zi_q <= sat_add(fx_val, fx_val);
          zr_q <= t_q;
        end
      end
      S_ZI: begin
        zi_q     <= sat_add(zi_q, ci_q);
        fx_neg_q <= 1'b0;
      end
      S_RR: begin
        if (mul_done) begin
          zr2_q <= fx_val;
        end
      end
      S_II: begin
        if (mul_done) begin
          zi2_q <= fx_val;
        end
      end
      S_ESC: begin
        esc_q  <= escape;
        near_q <= near;
        rem_q  <= '0;
      end
      S_MOD: begin
        rem_q <= rem_next[COLOR_BITS-1:0];
      end
      S_DONE: begin
        if (out_load) begin
          out_q.column_out <= pix_q.column;
          out_q.row_out    <= pix_q.row;
          out_q.iterations <= iter_q;
          out_q.escaped    <= esc_q;
          out_q.color      <= near_q ? max_color_q : rem_q;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // A product finishes only where the sequencer waits for one
  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_CX || state_q == S_CY || state_q == S_XY ||
                  state_q == S_RR || state_q == S_II))
    else $error("multiplier finished outside a waiting step");

  // The escape test sees a count between one and the limit
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ESC) |-> (iter_q != '0 && iter_q <= lim))
    else $error("iteration count out of range");

  // Squares never go negative
  a_squares_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ESC) |-> (!zr2_q[WORD_BITS-1] && !zi2_q[WORD_BITS-1]))
    else $error("negative square");

  // Partial remainder stays below the palette size
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD) |-> ({1'b0, rem_q} < divisor))
    else $error("color remainder out of range");
`endif

endmodule
